// ===== sv/mhpq_pkg.sv =====
// Shared types, constants and codes for the max-heap priority queue.
`timescale 1ns / 1ps
package mhpq_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CHILD_W  = ADDR_W + 2;
   localparam int DATA_W   = 32;
   localparam int RSP_CNT_W = 11;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_DELETE = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic                     func;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] max_value;
      logic [RSP_CNT_W-1:0]     count;
   } rsp_type;

   typedef struct packed {
      logic                     we;
      logic [ADDR_W-1:0]        waddr;
      logic signed [DATA_W-1:0] wdata;
      logic [ADDR_W-1:0]        raddr_a;
      logic [ADDR_W-1:0]        raddr_b;
   } ram_cmd_type;

endpackage

// ===== sv/mhpq_ram.sv =====
// Heap storage: one write port and two registered read ports.
`timescale 1ns / 1ps
module mhpq_ram (
   input  logic                             clock,
   input  mhpq_pkg::ram_cmd_type            cmd,
   output logic signed [mhpq_pkg::DATA_W-1:0] rdata_a,
   output logic signed [mhpq_pkg::DATA_W-1:0] rdata_b
);

   logic signed [mhpq_pkg::DATA_W-1:0] mem [mhpq_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr] <= cmd.wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_a <= mem[cmd.raddr_a];
      rdata_b <= mem[cmd.raddr_b];
   end

endmodule

// ===== sv/mhpq_ctrl.sv =====
// Sequencer for insert with sift-up and delete with sift-down over the heap memory.
`timescale 1ns / 1ps
module mhpq_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  mhpq_pkg::req_type                  req_data,
   input  logic                               res_free,
   output logic                               res_done,
   output mhpq_pkg::rsp_type                  res_word,
   output mhpq_pkg::ram_cmd_type              cmd,
   input  logic signed [mhpq_pkg::DATA_W-1:0] rdata_a,
   input  logic signed [mhpq_pkg::DATA_W-1:0] rdata_b
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_UP_CHK  = 3'd1;
   localparam logic [2:0] S_UP_CMP  = 3'd2;
   localparam logic [2:0] S_DN_ROOT = 3'd3;
   localparam logic [2:0] S_DN_LAST = 3'd4;
   localparam logic [2:0] S_DN_CHK  = 3'd5;
   localparam logic [2:0] S_DN_CMP  = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   localparam logic [mhpq_pkg::CNT_W-1:0] CAP_CNT = mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY);

   logic [2:0]                         state_ff, state_in;
   logic [mhpq_pkg::ADDR_W-1:0]        pos_ff, pos_in;
   logic [mhpq_pkg::CNT_W-1:0]         count_ff, count_in;
   logic signed [mhpq_pkg::DATA_W-1:0] val_ff, val_in;
   logic signed [mhpq_pkg::DATA_W-1:0] max_ff, max_in;
   logic [1:0]                         status_ff, status_in;

   logic [mhpq_pkg::ADDR_W-1:0]        parent;
   logic [mhpq_pkg::CHILD_W-1:0]       left, right, cnt_ext;
   logic                               has_right;
   logic                               pick_left, pick_right;
   logic signed [mhpq_pkg::DATA_W-1:0] left_best;

   assign parent     = (pos_ff - mhpq_pkg::ADDR_W'(1)) >> 1;
   assign left       = {1'b0, pos_ff, 1'b1};
   assign right      = left + mhpq_pkg::CHILD_W'(1);
   assign cnt_ext    = mhpq_pkg::CHILD_W'(count_ff);
   assign has_right  = right < cnt_ext;
   assign pick_left  = rdata_a > val_ff;
   assign left_best  = pick_left ? rdata_a : val_ff;
   assign pick_right = has_right && (rdata_b > left_best);

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      val_in    = val_ff;
      max_in    = max_ff;
      status_in = status_ff;
      cmd       = '0;
      res_done  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in    = req_data.value;
               max_in    = '0;
               status_in = mhpq_pkg::ST_OK;
               if (req_data.func == mhpq_pkg::FUNC_INSERT) begin
                  if (count_ff >= CAP_CNT) begin
                     status_in = mhpq_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     pos_in   = count_ff[mhpq_pkg::ADDR_W-1:0];
                     count_in = count_ff + mhpq_pkg::CNT_W'(1);
                     state_in = S_UP_CHK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = mhpq_pkg::ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     cmd.raddr_a = '0;
                     count_in    = count_ff - mhpq_pkg::CNT_W'(1);
                     state_in    = S_DN_ROOT;
                  end
               end
            end
         end
         S_UP_CHK: begin
            if (pos_ff == '0) begin
               cmd.we    = 1'b1;
               cmd.waddr = pos_ff;
               cmd.wdata = val_ff;
               state_in  = S_DONE;
            end else begin
               cmd.raddr_a = parent;
               state_in    = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            cmd.we    = 1'b1;
            cmd.waddr = pos_ff;
            if (val_ff > rdata_a) begin
               cmd.wdata = rdata_a;
               pos_in    = parent;
               state_in  = S_UP_CHK;
            end else begin
               cmd.wdata = val_ff;
               state_in  = S_DONE;
            end
         end
         S_DN_ROOT: begin
            max_in      = rdata_a;
            cmd.raddr_a = count_ff[mhpq_pkg::ADDR_W-1:0];
            state_in    = S_DN_LAST;
         end
         S_DN_LAST: begin
            val_in   = rdata_a;
            pos_in   = '0;
            state_in = S_DN_CHK;
         end
         S_DN_CHK: begin
            if (left >= cnt_ext) begin
               cmd.we    = 1'b1;
               cmd.waddr = pos_ff;
               cmd.wdata = val_ff;
               state_in  = S_DONE;
            end else begin
               cmd.raddr_a = left[mhpq_pkg::ADDR_W-1:0];
               cmd.raddr_b = right[mhpq_pkg::ADDR_W-1:0];
               state_in    = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            cmd.we    = 1'b1;
            cmd.waddr = pos_ff;
            if (pick_right) begin
               cmd.wdata = rdata_b;
               pos_in    = right[mhpq_pkg::ADDR_W-1:0];
               state_in  = S_DN_CHK;
            end else if (pick_left) begin
               cmd.wdata = rdata_a;
               pos_in    = left[mhpq_pkg::ADDR_W-1:0];
               state_in  = S_DN_CHK;
            end else begin
               cmd.wdata = val_ff;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (res_free) begin
               res_done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign res_word.status    = status_ff;
   assign res_word.max_value = max_ff;
   assign res_word.count     = mhpq_pkg::RSP_CNT_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      max_ff    <= max_in;
      status_ff <= status_in;
   end

endmodule

// ===== sv/max_heap_priority_queue_core.sv =====
// Top level of the max-heap priority queue: sequencer, heap memory and result register.
//
//   channel | direction | handshake             | word
//   req     | in        | req_valid / req_ready | req_data (func, value)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_data (status, max_value, count)
//
// One item at a time: the next request is taken only once the last one is done.
// Insert: from the new last slot, reads the parent and moves it down while the new
// value is larger, then writes the value. Delete: reads the root as the result, moves
// the last item to the root and sifts it down. Full insert, empty delete: straight to done.
// Each level costs one memory read and one compare/write-back on the heap memory.
// Reset empties the heap at once; the memory itself is not cleared.
// A waiting result blocks the next request only while it is not being taken: the
// sequencer holds in its final step, with req_ready low, while the result register is full.
`timescale 1ns / 1ps
module max_heap_priority_queue_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mhpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mhpq_pkg::rsp_type rsp_data
);

   mhpq_pkg::ram_cmd_type              cmd;
   logic signed [mhpq_pkg::DATA_W-1:0] rdata_a, rdata_b;
   logic                               res_free, res_done;
   mhpq_pkg::rsp_type                  res_word;
   logic                               rsp_valid_ff, rsp_valid_in;
   mhpq_pkg::rsp_type                  rsp_ff, rsp_in;

   mhpq_ram u_ram (
      .clock   (clock),
      .cmd     (cmd),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_free  (res_free),
      .res_done  (res_done),
      .res_word  (res_word),
      .cmd       (cmd),
      .rdata_a   (rdata_a),
      .rdata_b   (rdata_b)
   );

   assign res_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_word;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an operation is in flight");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == mhpq_pkg::ST_EMPTY) |-> (rsp_data.count == '0))
      else $error("empty status with nonzero count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == mhpq_pkg::ST_FULL)
      |-> (rsp_data.count == mhpq_pkg::RSP_CNT_W'(mhpq_pkg::CAPACITY)))
      else $error("full status with count below capacity");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != mhpq_pkg::ST_OK) |-> (rsp_data.max_value == '0))
      else $error("failed operation returned a nonzero value");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !res_done)
      else $error("result produced while output register is full");

endmodule
